>>> sv/dsu_pkg.sv
// Shared types and constants for the disjoint-set union-find block.
// No dependencies; the top level and the sequencer import this package.
package dsu_pkg;

  // Port field widths fixed by the item format.
  localparam int ELEM_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 11;

  // Reset value of the active element count register.
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 11'd1024;

  // Command codes carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_UNITE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_FIX,
    ST_SIZE_U,
    ST_SIZE_V,
    ST_RESULT
  } state_t;

endpackage

>>> sv/disjoint_set_union_find_top.sv
// Top level of the disjoint-set union-find block: active element register,
// sequencer and the two tables. Depends on dsu_pkg, dsu_ram and dsu_ctrl.
//
//   channel   direction   handshake             payload
//   in        to block    in_valid / in_stall    in_command, in_elem_u, in_elem_v
//   out       from block  out_valid / out_stall  out_root, out_set_size, out_same_set,
//                                               out_merged, out_set_count, out_error
//   cfg       to block    cfg_wr_en             cfg_wr_data (active_elements)
//
// A find follows the parent links from the start element up to its root, then walks the
// path again to point each element at the root; unite and query run two finds plus one
// or two more size reads. Each cycle follows one parent link through the single read port
// of the parent table. A clear sweeps L table entries, one per cycle (L = live count),
// and after reset the same sweep runs with in_stall high. Errors go straight to the result.
// The result register lets a new item enter while the previous result is stalled.
module disjoint_set_union_find_top #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [dsu_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dsu_pkg::CMD_W-1:0]     in_command,
  input  logic [dsu_pkg::ELEM_W-1:0]    in_elem_u,
  input  logic [dsu_pkg::ELEM_W-1:0]    in_elem_v,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsu_pkg::ELEM_W-1:0]    out_root,
  output logic [dsu_pkg::SIZE_W-1:0]    out_set_size,
  output logic                          out_same_set,
  output logic                          out_merged,
  output logic [dsu_pkg::SIZE_W-1:0]    out_set_count,
  output logic                          out_error
);

  import dsu_pkg::*;

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int SW = $clog2(MAX_ELEMENTS + 1);

  logic [CFG_W-1:0] cfg_active_r;

  logic          p_we;
  logic [IW-1:0] p_waddr;
  logic [IW-1:0] p_wdata;
  logic [IW-1:0] p_raddr;
  logic [IW-1:0] p_rdata;
  logic          s_we;
  logic [IW-1:0] s_waddr;
  logic [SW-1:0] s_wdata;
  logic [IW-1:0] s_raddr;
  logic [SW-1:0] s_rdata;

  // Active element count; takes effect at the next clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      cfg_active_r <= cfg_wr_data;
    end
  end

  // Sequencer.
  dsu_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_active    (cfg_active_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_elem_u     (in_elem_u),
    .in_elem_v     (in_elem_v),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_root      (out_root),
    .out_set_size  (out_set_size),
    .out_same_set  (out_same_set),
    .out_merged    (out_merged),
    .out_set_count (out_set_count),
    .out_error     (out_error),
    .p_we          (p_we),
    .p_waddr       (p_waddr),
    .p_wdata       (p_wdata),
    .p_raddr       (p_raddr),
    .p_rdata       (p_rdata),
    .s_we          (s_we),
    .s_waddr       (s_waddr),
    .s_wdata       (s_wdata),
    .s_raddr       (s_raddr),
    .s_rdata       (s_rdata)
  );

  // Parent link table.
  dsu_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_ELEMENTS)
  ) u_parent_ram (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .rd_addr (p_raddr),
    .rd_data (p_rdata)
  );

  // Set size table, meaningful at roots.
  dsu_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ELEMENTS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (s_waddr),
    .wr_data (s_wdata),
    .rd_addr (s_raddr),
    .rd_data (s_rdata)
  );

endmodule

>>> sv/dsu_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the parent link table and the set size table; no package needed.
module dsu_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/dsu_ctrl.sv
// Sequencer of the union-find block: walks parent links, compresses paths,
// merges sets and holds the result register. Depends on dsu_pkg and two dsu_ram tables.
module dsu_ctrl #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dsu_pkg::CFG_W-1:0]           cfg_active,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dsu_pkg::CMD_W-1:0]           in_command,
  input  logic [dsu_pkg::ELEM_W-1:0]          in_elem_u,
  input  logic [dsu_pkg::ELEM_W-1:0]          in_elem_v,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dsu_pkg::ELEM_W-1:0]          out_root,
  output logic [dsu_pkg::SIZE_W-1:0]          out_set_size,
  output logic                                out_same_set,
  output logic                                out_merged,
  output logic [dsu_pkg::SIZE_W-1:0]          out_set_count,
  output logic                                out_error,
  output logic                                p_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0]     p_waddr,
  output logic [$clog2(MAX_ELEMENTS)-1:0]     p_wdata,
  output logic [$clog2(MAX_ELEMENTS)-1:0]     p_raddr,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]     p_rdata,
  output logic                                s_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0]     s_waddr,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0]   s_wdata,
  output logic [$clog2(MAX_ELEMENTS)-1:0]     s_raddr,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0]   s_rdata
);

  import dsu_pkg::*;

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int SW = $clog2(MAX_ELEMENTS + 1);

  // Saturate a requested element count into 1..MAX_ELEMENTS.
  function automatic logic [SW-1:0] clamp_live(input logic [CFG_W-1:0] val);
    logic [SW-1:0] res;
    if (val == '0) begin
      res = SW'(1);
    end else if (32'(val) > MAX_ELEMENTS) begin
      res = SW'(MAX_ELEMENTS);
    end else begin
      res = SW'(val);
    end
    return res;
  endfunction

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [IW-1:0]   u_r, u_nxt;
  logic [IW-1:0]   v_r, v_nxt;
  logic [IW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   root_r, root_nxt;
  logic [IW-1:0]   ru_r, ru_nxt;
  logic            second_r, second_nxt;
  logic [SW-1:0]   size_u_r, size_u_nxt;
  logic [SW-1:0]   live_r, live_nxt;
  logic [SW-1:0]   sets_r, sets_nxt;
  logic [IW-1:0]   sweep_r, sweep_nxt;
  logic            from_cmd_r, from_cmd_nxt;

  logic [IW-1:0]   res_root_r, res_root_nxt;
  logic [SW-1:0]   res_size_r, res_size_nxt;
  logic            res_same_r, res_same_nxt;
  logic            res_merged_r, res_merged_nxt;
  logic            res_err_r, res_err_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0]   out_root_r, out_root_nxt;
  logic [SIZE_W-1:0]   out_set_size_r, out_set_size_nxt;
  logic                out_same_set_r, out_same_set_nxt;
  logic                out_merged_r, out_merged_nxt;
  logic [SIZE_W-1:0]   out_set_count_r, out_set_count_nxt;
  logic                out_error_r, out_error_nxt;

  cmd_t            in_cmd;
  logic            accept;
  logic            in_err;
  logic            walk_hit;
  logic            fix_done;
  logic            sweep_last;
  logic            out_free;
  logic [IW-1:0]   start_elem;
  logic            v_bigger;
  logic [IW-1:0]   winner;
  logic [IW-1:0]   loser;
  logic [SW-1:0]   sum_uv;

  // Shared conditions.
  assign in_cmd     = cmd_t'(in_command);
  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign in_err     = (32'(in_elem_u) >= 32'(live_r)) ||
                      ((in_cmd != CMD_FIND) && (32'(in_elem_v) >= 32'(live_r)));
  assign walk_hit   = (p_rdata == cur_r);
  assign fix_done   = (cur_r == root_r);
  assign sweep_last = (SW'(sweep_r) == (live_r - SW'(1)));
  assign out_free   = !out_valid_r || !out_stall;
  assign start_elem = second_r ? v_r : u_r;
  assign v_bigger   = (s_rdata > size_u_r);
  assign winner     = v_bigger ? root_r : ru_r;
  assign loser      = v_bigger ? ru_r : root_r;
  assign sum_uv     = size_u_r + s_rdata;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_err) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_CLEAR: begin
        if (sweep_last) begin
          state_nxt = from_cmd_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_WALK: begin
        if (walk_hit) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (fix_done) begin
          state_nxt = ((cmd_r == CMD_FIND) || second_r) ? ST_SIZE_U : ST_WALK;
        end
      end
      ST_SIZE_U: begin
        state_nxt = ((cmd_r == CMD_UNITE) && (ru_r != root_r)) ? ST_SIZE_V : ST_RESULT;
      end
      ST_SIZE_V: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, table accesses and result loading.
  always_comb begin
    cmd_nxt           = cmd_r;
    u_nxt             = u_r;
    v_nxt             = v_r;
    cur_nxt           = cur_r;
    root_nxt          = root_r;
    ru_nxt            = ru_r;
    second_nxt        = second_r;
    size_u_nxt        = size_u_r;
    live_nxt          = live_r;
    sets_nxt          = sets_r;
    sweep_nxt         = sweep_r;
    from_cmd_nxt      = from_cmd_r;
    res_root_nxt      = res_root_r;
    res_size_nxt      = res_size_r;
    res_same_nxt      = res_same_r;
    res_merged_nxt    = res_merged_r;
    res_err_nxt       = res_err_r;
    out_root_nxt      = out_root_r;
    out_set_size_nxt  = out_set_size_r;
    out_same_set_nxt  = out_same_set_r;
    out_merged_nxt    = out_merged_r;
    out_set_count_nxt = out_set_count_r;
    out_error_nxt     = out_error_r;
    p_we              = 1'b0;
    p_waddr           = cur_r;
    p_wdata           = root_r;
    p_raddr           = cur_r;
    s_we              = 1'b0;
    s_waddr           = winner;
    s_wdata           = sum_uv;
    s_raddr           = root_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          u_nxt      = IW'(in_elem_u);
          v_nxt      = IW'(in_elem_v);
          second_nxt = 1'b0;
          if (in_cmd == CMD_CLEAR) begin
            live_nxt     = clamp_live(cfg_active);
            sets_nxt     = clamp_live(cfg_active);
            sweep_nxt    = '0;
            from_cmd_nxt = 1'b1;
          end else if (in_err) begin
            res_root_nxt   = '0;
            res_size_nxt   = '0;
            res_same_nxt   = 1'b0;
            res_merged_nxt = 1'b0;
            res_err_nxt    = 1'b1;
          end else begin
            cur_nxt = IW'(in_elem_u);
            p_raddr = IW'(in_elem_u);
          end
        end
      end
      ST_CLEAR: begin
        // One entry per cycle back to a singleton.
        p_we           = 1'b1;
        p_waddr        = sweep_r;
        p_wdata        = sweep_r;
        s_we           = 1'b1;
        s_waddr        = sweep_r;
        s_wdata        = SW'(1);
        sweep_nxt      = sweep_r + IW'(1);
        res_root_nxt   = '0;
        res_size_nxt   = SW'(1);
        res_same_nxt   = 1'b0;
        res_merged_nxt = 1'b0;
        res_err_nxt    = 1'b0;
      end
      ST_WALK: begin
        // Follow one parent link per cycle; restart at the start for compression.
        if (walk_hit) begin
          root_nxt = cur_r;
          cur_nxt  = start_elem;
          p_raddr  = start_elem;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end
      ST_FIX: begin
        // Point each element on the path at the root.
        if (!fix_done) begin
          p_we    = 1'b1;
          p_waddr = cur_r;
          p_wdata = root_r;
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end else begin
          s_raddr = second_r ? ru_r : root_r;
          if (!second_r) begin
            ru_nxt = root_r;
            if (cmd_r != CMD_FIND) begin
              second_nxt = 1'b1;
              cur_nxt    = v_r;
              p_raddr    = v_r;
            end
          end
        end
      end
      ST_SIZE_U: begin
        size_u_nxt = s_rdata;
        if ((cmd_r == CMD_UNITE) && (ru_r != root_r)) begin
          s_raddr = root_r;
        end else begin
          res_root_nxt   = ru_r;
          res_size_nxt   = s_rdata;
          res_same_nxt   = (cmd_r != CMD_FIND) && (ru_r == root_r);
          res_merged_nxt = 1'b0;
          res_err_nxt    = 1'b0;
        end
      end
      ST_SIZE_V: begin
        // Larger set's root becomes parent; a tie keeps the root of u.
        p_we    = 1'b1;
        p_waddr = loser;
        p_wdata = winner;
        s_we    = 1'b1;
        s_waddr = winner;
        s_wdata = sum_uv;
        if (sets_r > SW'(1)) begin
          sets_nxt = sets_r - SW'(1);
        end
        res_root_nxt   = winner;
        res_size_nxt   = sum_uv;
        res_same_nxt   = 1'b0;
        res_merged_nxt = 1'b1;
        res_err_nxt    = 1'b0;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_root_nxt      = ELEM_W'(res_root_r);
          out_set_size_nxt  = SIZE_W'(res_size_r);
          out_same_set_nxt  = res_same_r;
          out_merged_nxt    = res_merged_r;
          out_set_count_nxt = SIZE_W'(sets_r);
          out_error_nxt     = res_err_r;
        end
      end
      default: begin
        cmd_nxt = cmd_r;
      end
    endcase
  end

  // Output valid: set when a result loads, cleared when taken.
  assign out_valid_nxt = ((state_r == ST_RESULT) && out_free) ? 1'b1 :
                         (out_valid_r && out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      live_r      <= clamp_live(ACTIVE_RESET);
      sets_r      <= clamp_live(ACTIVE_RESET);
      sweep_r     <= '0;
      from_cmd_r  <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      sets_r      <= sets_nxt;
      sweep_r     <= sweep_nxt;
      from_cmd_r  <= from_cmd_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    u_r             <= u_nxt;
    v_r             <= v_nxt;
    cur_r           <= cur_nxt;
    root_r          <= root_nxt;
    ru_r            <= ru_nxt;
    size_u_r        <= size_u_nxt;
    res_root_r      <= res_root_nxt;
    res_size_r      <= res_size_nxt;
    res_same_r      <= res_same_nxt;
    res_merged_r    <= res_merged_nxt;
    res_err_r       <= res_err_nxt;
    out_root_r      <= out_root_nxt;
    out_set_size_r  <= out_set_size_nxt;
    out_same_set_r  <= out_same_set_nxt;
    out_merged_r    <= out_merged_nxt;
    out_set_count_r <= out_set_count_nxt;
    out_error_r     <= out_error_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_root      = out_root_r;
  assign out_set_size  = out_set_size_r;
  assign out_same_set  = out_same_set_r;
  assign out_merged    = out_merged_r;
  assign out_set_count = out_set_count_r;
  assign out_error     = out_error_r;

`ifndef SYNTHESIS
  // The set count stays between one and the live element count.
  a_sets_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sets_r != '0) && (sets_r <= live_r))
    else $error("set count out of range");

  // A merge of two sets lowers the set count by one.
  a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SIZE_V) && (sets_r > SW'(1))) |=> (sets_r == $past(sets_r) - SW'(1)))
    else $error("merge did not lower the set count");

  // An error item carries an empty result.
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> ((out_set_size_r == '0) && !out_merged_r))
    else $error("error item with a non-empty result");

  // A merge only happens between different sets.
  a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_merged_r) |-> !out_same_set_r)
    else $error("merge reported for one set");
`endif

endmodule
